// ===== design/nrdiv_pkg.sv =====
// ----------------------------------------------------------------------------
// nrdiv_pkg
// Shared width constant, step result type and the one-step function of the
// unsigned non-restoring divider.
// ----------------------------------------------------------------------------
`default_nettype none

package nrdiv_pkg;

    // Operand width; the accumulator carries one extra sign bit
    localparam int DW = 8;

    typedef logic [DW-1:0] word_t;
    typedef logic [DW:0]   acc_t;

    // Partial remainder and quotient after one iteration
    typedef struct packed {
        acc_t  acc;
        word_t quo;
    } step_t;

    // One non-restoring iteration: shift, then add or subtract by old sign
    function automatic step_t nrd_step(input acc_t acc, input word_t quo,
                                       input word_t dsr);
        acc_t  sh;
        acc_t  nx;
        step_t res;
        sh = {acc[DW-1:0], quo[DW-1]};
        if (acc[DW])
            nx = sh + {1'b0, dsr};
        else
            nx = sh - {1'b0, dsr};
        res.acc = nx;
        res.quo = {quo[DW-2:0], ~nx[DW]};
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== design/nonrestoring_divider.sv =====
// ----------------------------------------------------------------------------
// nonrestoring_divider
// Pipelined unsigned non-restoring divider: one register stage per quotient
// bit and one output stage that applies the final remainder correction.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel  : in_valid / in_stall carry dividend and divisor. A
//                    transfer happens at a clock edge with in_valid high and
//                    in_stall low.
//   Output channel : out_valid / out_stall carry quotient and remainder, one
//                    result per input transfer, in order.
//   Path           : an input transfer passes through the iteration stages
//                    and then the output stage before out_valid rises.
//   Throughput     : one division per cycle while the output is not stalled;
//                    each stage holds one item and runs one add/subtract of the DW+1 bit accumulator.
//   Zero divisor   : quotient is all ones, remainder equals the dividend.
//   Reset          : rst_n clears every stage valid bit; the pipe is empty.
//   Output stall   : the output stage holds its result; stages behind it
//                    keep moving into empty slots, and in_stall rises only
//                    once every stage holds an item.
// ----------------------------------------------------------------------------
`default_nettype none

module nonrestoring_divider (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire nrdiv_pkg::word_t  dividend,
    input  wire nrdiv_pkg::word_t  divisor,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output nrdiv_pkg::word_t       quotient,
    output nrdiv_pkg::word_t       remainder
);
    import nrdiv_pkg::*;

    // Iteration stages
    logic [DW-1:0] vld_reg;
    acc_t          acc_reg [DW];
    word_t         quo_reg [DW];
    word_t         dsr_reg [DW];

    // Output stage
    logic          out_valid_reg;
    word_t         quo_out_reg;
    word_t         rem_out_reg;
    word_t         dsr_out_reg;

    // Stage inputs and one-step results
    logic [DW-1:0] src_vld;
    acc_t          src_acc [DW];
    word_t         src_quo [DW];
    word_t         src_dsr [DW];
    step_t         step_next [DW];
    logic [DW:0]   rdy;
    acc_t          rem_fix;

    // Feed each stage from the one before, stage zero from the ports
    always_comb
    begin
        src_vld[0] = in_valid;
        src_acc[0] = '0;
        src_quo[0] = dividend;
        src_dsr[0] = divisor;
        for (int k = 1; k < DW; k++)
        begin
            src_vld[k] = vld_reg[k-1];
            src_acc[k] = acc_reg[k-1];
            src_quo[k] = quo_reg[k-1];
            src_dsr[k] = dsr_reg[k-1];
        end
        for (int k = 0; k < DW; k++)
            step_next[k] = nrd_step(src_acc[k], src_quo[k], src_dsr[k]);
    end

    // A stage may load when it is empty or its content moves on
    always_comb
    begin
        rdy[DW] = !out_valid_reg || !out_stall;
        for (int k = DW - 1; k >= 0; k--)
            rdy[k] = !vld_reg[k] || rdy[k+1];
    end

    assign in_stall = !rdy[0];

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            for (int k = 0; k < DW; k++)
                if (rdy[k])
                    vld_reg[k] <= src_vld[k];
            if (rdy[DW])
                out_valid_reg <= vld_reg[DW-1];
        end
    end

    // Advance iteration payload
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < DW; k++)
        begin
            if (rdy[k] && src_vld[k])
            begin
                acc_reg[k] <= step_next[k].acc;
                quo_reg[k] <= step_next[k].quo;
                dsr_reg[k] <= src_dsr[k];
            end
        end
    end

    // Add the divisor back to a negative final remainder
    always_comb
    begin
        if (acc_reg[DW-1][DW])
            rem_fix = acc_reg[DW-1] + {1'b0, dsr_reg[DW-1]};
        else
            rem_fix = acc_reg[DW-1];
    end

    // Load the output stage
    always_ff @(posedge clk)
    begin
        if (rdy[DW] && vld_reg[DW-1])
        begin
            quo_out_reg <= quo_reg[DW-1];
            rem_out_reg <= rem_fix[DW-1:0];
            dsr_out_reg <= dsr_reg[DW-1];
        end
    end

    assign out_valid = out_valid_reg;
    assign quotient  = quo_out_reg;
    assign remainder = rem_out_reg;

    // Remainder stays below a nonzero divisor
    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (dsr_out_reg != '0) |-> rem_out_reg < dsr_out_reg)
        else $error("remainder not below divisor");

    // Zero divisor yields an all-ones quotient
    a_zero_dsr: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (dsr_out_reg == '0) |-> (&quo_out_reg))
        else $error("zero divisor quotient not all ones");

    // Input is held back only when every stage is occupied
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> ((&vld_reg) && out_valid_reg && out_stall))
        else $error("input stalled with an empty stage");

    // A stalled output item stays in place
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |=> out_valid_reg && $stable(rem_out_reg)
        && $stable(dsr_out_reg))
        else $error("output stage dropped a stalled result");

endmodule

`default_nettype wire
